// ----- design/assert_macros.svh -----
// Assertion macros shared by the track parser modules.
// Each needs a clock clk in scope; ASSERT_CLKD also an active-low reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define ASSERT_CLKD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/mtep_pkg.sv -----
// Shared types and constants of the MIDI track event parser.
// Used by the front, queue, back and top level modules; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mtep_pkg;

  localparam int unsigned UNIT_BYTES = 8;
  localparam int unsigned LANE_BITS = $clog2(UNIT_BYTES);

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_LENGTH  = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_END     = 2'd3;

  localparam logic [7:0] STATUS_META   = 8'hFF;
  localparam logic [7:0] STATUS_SYSEX  = 8'hF0;
  localparam logic [7:0] STATUS_ESCAPE = 8'hF7;
  localparam logic [3:0] NIBBLE_SYSTEM = 4'hF;
  localparam logic [3:0] NIBBLE_PROG   = 4'hC;
  localparam logic [3:0] NIBBLE_PRESS  = 4'hD;
  localparam logic [7:0] META_END      = 8'h2F;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       msb;
    logic       hi_system;
    logic       short_msg;
    logic       is_meta;
    logic       is_sysex;
    logic       is_end_type;
  } byte_class_t;

  typedef struct packed {
    logic        valid;
    byte_class_t entry;
  } queue_head_t;

endpackage

`default_nettype wire

// ----- design/midi_track_event_parser.sv -----
// Top level of the MIDI track event parser: front end, byte queue and parser core.
// Depends on mtep_pkg, mtep_front, mtep_queue and mtep_back.
//
// Channel  Direction  tdata                                    tuser           tlast
// in_      slave      [7:0] track_byte                         [0] track_start  none
// out_     master     [31:0] delta_time, [63:32] event_word    [1:0] unit_kind  end_of_track
//
// One byte is taken every cycle while the queue has room; the core retires one queued
// byte per cycle unless the output stalls, and registers each result beat it forms.
// The queue holds QUEUE_DEPTH bytes and lets input keep flowing while the output stalls.
// Reset is synchronous and clears the queue, the parser state and the output valid flag.
// A stalled output holds its beat and pauses the core; input stops once the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module midi_track_event_parser #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] track_byte
  input  wire logic [0:0]  in_tuser,   // [0] track_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [31:0] delta_time, [63:32] event_word
  output logic [1:0]       out_tuser,  // [1:0] unit_kind
  output logic             out_tlast
);

  mtep_pkg::byte_class_t push_entry;
  mtep_pkg::queue_head_t head;
  logic                  q_push;
  logic                  q_full;
  logic                  q_pop;

  mtep_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  mtep_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (head)
  );

  mtep_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ----- design/mtep_front.sv -----
// Front end of the track parser: takes input beats and tags each byte with its class.
// Depends on mtep_pkg; feeds mtep_queue.
`timescale 1ns / 1ps
`default_nettype none

module mtep_front (
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,
  input  wire logic [0:0]           in_tuser,
  input  wire logic                 q_full,
  output logic                      q_push,
  output mtep_pkg::byte_class_t     q_entry
);

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_entry             = '0;
    q_entry.data        = in_tdata;
    q_entry.start       = in_tuser[0];
    q_entry.msb         = in_tdata[7];
    q_entry.hi_system   = (in_tdata[7:4] == mtep_pkg::NIBBLE_SYSTEM);
    q_entry.short_msg   = (in_tdata[7:4] == mtep_pkg::NIBBLE_PROG) ||
                          (in_tdata[7:4] == mtep_pkg::NIBBLE_PRESS);
    q_entry.is_meta     = (in_tdata == mtep_pkg::STATUS_META);
    q_entry.is_sysex    = (in_tdata == mtep_pkg::STATUS_SYSEX) ||
                          (in_tdata == mtep_pkg::STATUS_ESCAPE);
    q_entry.is_end_type = (in_tdata == mtep_pkg::META_END);
  end

endmodule

`default_nettype wire

// ----- design/mtep_queue.sv -----
// Short queue of classified bytes between the front end and the parser core.
// Depends on mtep_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mtep_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire mtep_pkg::byte_class_t push_entry,
  output logic                       full,
  input  wire logic                  pop,
  output mtep_pkg::queue_head_t      head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mtep_pkg::byte_class_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head       = {(count_r != '0), slot_r[rd_ptr_r]};
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `ASSERT_CLKD(a_count_bound, count_r <= CW'(DEPTH), "queue fill count beyond depth")

endmodule

`default_nettype wire

// ----- design/mtep_back.sv -----
// Parser core: walks the track grammar one queued byte per cycle unless stalled.
// Registers result beats. Depends on mtep_pkg and assert_macros.svh; fed by mtep_queue.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mtep_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mtep_pkg::queue_head_t head,
  output logic                       pop,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [63:0]                out_tdata,
  output logic [1:0]                 out_tuser,
  output logic                       out_tlast
);

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_DATA1,
    PH_DATA2,
    PH_META,
    PH_LENGTH,
    PH_PAYLOAD
  } phase_t;

  localparam int unsigned LB = mtep_pkg::LANE_BITS;
  localparam int unsigned NB = mtep_pkg::UNIT_BYTES;

  phase_t      phase_r, phase_nxt, cur_phase;
  logic [31:0] acc_r, acc_nxt, cur_acc;
  logic [31:0] held_r, held_nxt, cur_held;
  logic [7:0]  status_r, status_nxt, cur_status;
  logic        short_r, short_nxt, cur_short;
  logic [7:0]  running_r, running_nxt, cur_running;
  logic        run_short_r, run_short_nxt, cur_run_short;
  logic [7:0]  first_r, first_nxt, cur_first;
  logic        meta_end_r, meta_end_nxt, cur_meta_end;
  logic [31:0] left_r, left_nxt, cur_left;
  logic [7:0]  buf_r [NB];
  logic [7:0]  buf_nxt [NB];
  logic [7:0]  cur_buf [NB];
  logic [7:0]  merged [NB];
  logic [LB-1:0] pos_r, pos_nxt, cur_pos;
  logic        done_r, done_nxt, cur_done;

  logic        out_valid_r;
  logic [31:0] out_lo_r, out_hi_r;
  logic [1:0]  out_kind_r;
  logic        out_last_r;

  logic        emit;
  logic [31:0] e_lo, e_hi;
  logic [1:0]  e_kind;
  logic        e_last;
  logic [31:0] shifted;
  logic [28:0] len_units;
  logic        pay_last;
  logic [63:0] merged_flat;
  mtep_pkg::byte_class_t e;

  assign e          = head.entry;
  assign pop        = head.valid && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_hi_r, out_lo_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    cur_phase     = e.start ? PH_DELTA : phase_r;
    cur_acc       = e.start ? '0 : acc_r;
    cur_held      = e.start ? '0 : held_r;
    cur_status    = e.start ? '0 : status_r;
    cur_short     = e.start ? 1'b0 : short_r;
    cur_running   = e.start ? '0 : running_r;
    cur_run_short = e.start ? 1'b0 : run_short_r;
    cur_first     = e.start ? '0 : first_r;
    cur_meta_end  = e.start ? 1'b0 : meta_end_r;
    cur_left      = e.start ? '0 : left_r;
    cur_pos       = e.start ? '0 : pos_r;
    cur_done      = e.start ? 1'b0 : done_r;
    for (int i = 0; i < NB; i++) begin
      cur_buf[i] = e.start ? 8'h00 : buf_r[i];
      merged[i]  = (cur_pos == LB'(i)) ? e.data : cur_buf[i];
    end
    for (int i = 0; i < NB; i++) begin
      merged_flat[8*i +: 8] = merged[i];
    end
    shifted   = {cur_acc[24:0], e.data[6:0]};
    len_units = shifted[31:3];
    pay_last  = (cur_left == 32'd1);
  end

  always_comb begin
    phase_nxt     = cur_phase;
    acc_nxt       = cur_acc;
    held_nxt      = cur_held;
    status_nxt    = cur_status;
    short_nxt     = cur_short;
    running_nxt   = cur_running;
    run_short_nxt = cur_run_short;
    first_nxt     = cur_first;
    meta_end_nxt  = cur_meta_end;
    left_nxt      = cur_left;
    buf_nxt       = cur_buf;
    pos_nxt       = cur_pos;
    done_nxt      = cur_done;
    emit          = 1'b0;
    e_lo          = cur_held;
    e_hi          = '0;
    e_kind        = mtep_pkg::KIND_HEADER;
    e_last        = 1'b0;
    if (!cur_done) begin
      unique case (cur_phase)
        PH_DELTA: begin
          acc_nxt = shifted;
          if (!e.msb) begin
            held_nxt  = shifted;
            acc_nxt   = '0;
            phase_nxt = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (!e.msb) begin
            status_nxt = cur_running;
            short_nxt  = cur_run_short;
            first_nxt  = e.data;
            if (cur_run_short) begin
              phase_nxt = PH_DELTA;
              emit      = 1'b1;
              e_hi      = {16'h0000, e.data, cur_running};
            end else begin
              phase_nxt = PH_DATA2;
            end
          end else begin
            status_nxt = e.data;
            short_nxt  = e.short_msg;
            if (!e.hi_system) begin
              phase_nxt = PH_DATA1;
            end else if (e.is_meta) begin
              running_nxt   = '0;
              run_short_nxt = 1'b0;
              phase_nxt     = PH_META;
            end else if (e.is_sysex) begin
              running_nxt   = '0;
              run_short_nxt = 1'b0;
              phase_nxt     = PH_LENGTH;
              emit          = 1'b1;
              e_hi          = {24'h000000, e.data};
            end else begin
              phase_nxt = PH_DELTA;
              emit      = 1'b1;
            end
          end
        end
        PH_DATA1: begin
          first_nxt = e.data;
          if (cur_short) begin
            running_nxt   = cur_status;
            run_short_nxt = 1'b1;
            phase_nxt     = PH_DELTA;
            emit          = 1'b1;
            e_hi          = {16'h0000, e.data, cur_status};
          end else begin
            phase_nxt = PH_DATA2;
          end
        end
        PH_DATA2: begin
          running_nxt   = cur_status;
          run_short_nxt = cur_short;
          phase_nxt     = PH_DELTA;
          emit          = 1'b1;
          e_hi          = {8'h00, e.data, cur_first, cur_status};
        end
        PH_META: begin
          meta_end_nxt = e.is_end_type;
          phase_nxt    = PH_LENGTH;
          if (!e.is_end_type) begin
            emit = 1'b1;
            e_hi = {16'h0000, e.data, mtep_pkg::STATUS_META};
          end
        end
        PH_LENGTH: begin
          if (e.msb) begin
            acc_nxt = shifted;
          end else begin
            acc_nxt = '0;
            if ((cur_status == mtep_pkg::STATUS_META) && cur_meta_end) begin
              done_nxt  = 1'b1;
              phase_nxt = PH_DELTA;
              emit      = 1'b1;
              e_lo      = '0;
              e_kind    = mtep_pkg::KIND_END;
              e_last    = 1'b1;
            end else begin
              for (int i = 0; i < NB; i++) begin
                buf_nxt[i] = 8'h00;
              end
              pos_nxt  = '0;
              left_nxt = shifted;
              emit     = 1'b1;
              e_kind   = mtep_pkg::KIND_LENGTH;
              if ((cur_status == mtep_pkg::STATUS_SYSEX) && (shifted != '0)) begin
                e_lo       = (shifted == '1) ? shifted : shifted + 32'd1;
                e_hi       = {3'b000, len_units} + 32'd1;
                buf_nxt[0] = mtep_pkg::STATUS_SYSEX;
                pos_nxt    = LB'(1);
              end else begin
                e_lo = shifted;
                e_hi = {3'b000, len_units} + {31'd0, (shifted[2:0] != 3'b000)};
              end
              phase_nxt = (shifted != '0) ? PH_PAYLOAD : PH_DELTA;
            end
          end
        end
        PH_PAYLOAD: begin
          left_nxt = cur_left - 32'd1;
          if ((cur_pos == LB'(NB - 1)) || pay_last) begin
            for (int i = 0; i < NB; i++) begin
              buf_nxt[i] = 8'h00;
            end
            pos_nxt = '0;
            if (pay_last) begin
              phase_nxt = PH_DELTA;
            end
            emit   = 1'b1;
            e_lo   = merged_flat[31:0];
            e_hi   = merged_flat[63:32];
            e_kind = mtep_pkg::KIND_PAYLOAD;
          end else begin
            buf_nxt = merged;
            pos_nxt = cur_pos + 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_DELTA;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DELTA;
      acc_r       <= '0;
      held_r      <= '0;
      status_r    <= '0;
      short_r     <= 1'b0;
      running_r   <= '0;
      run_short_r <= 1'b0;
      first_r     <= '0;
      meta_end_r  <= 1'b0;
      left_r      <= '0;
      pos_r       <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NB; i++) begin
        buf_r[i] <= 8'h00;
      end
    end else begin
      if (pop) begin
        phase_r     <= phase_nxt;
        acc_r       <= acc_nxt;
        held_r      <= held_nxt;
        status_r    <= status_nxt;
        short_r     <= short_nxt;
        running_r   <= running_nxt;
        run_short_r <= run_short_nxt;
        first_r     <= first_nxt;
        meta_end_r  <= meta_end_nxt;
        left_r      <= left_nxt;
        pos_r       <= pos_nxt;
        done_r      <= done_nxt;
        buf_r       <= buf_nxt;
      end
      if (pop && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_lo_r   <= e_lo;
      out_hi_r   <= e_hi;
      out_kind_r <= e_kind;
      out_last_r <= e_last;
    end
  end

  `ASSERT_CLKD(a_done_idle, done_r |-> (phase_r == PH_DELTA), "finished track left delta phase")
  `ASSERT_CLKD(a_payload_left, (phase_r == PH_PAYLOAD) |-> (left_r != '0),
               "payload phase with no bytes left")
  `ASSERT_CLKD(a_end_last, out_valid_r |-> ((out_kind_r == mtep_pkg::KIND_END) == out_last_r),
               "end unit and last flag disagree")

endmodule

`default_nettype wire

// ----- tb/midi_track_event_parser_tb.sv -----
// Self-checking testbench for the MIDI track event parser: directed track fragments, then
// random event streams. It depends only on mtep_pkg and the midi_track_event_parser top.
`timescale 1ns / 1ps

module midi_track_event_parser_tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 800;

  typedef enum logic [3:0] {
    WAIT_DELTA, WAIT_STATUS, WAIT_DATA1, WAIT_DATA2, WAIT_META_TYPE, WAIT_LENGTH, WAIT_PAYLOAD
  } phase_t;

  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
    logic [1:0]  kind;
    logic        last;
  } unit_t;

  typedef logic [7:0] byte_seq_t[$];

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] track_byte
  logic [0:0]  in_tuser = '0;   // [0] track_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // [31:0] delta_time, [63:32] event_word
  logic [1:0]  out_tuser;       // [1:0] unit_kind
  logic        out_tlast;

  midi_track_event_parser u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  phase_t      phase = WAIT_DELTA;
  logic [31:0] vlq_acc = '0;
  logic [31:0] held_delta = '0;
  logic [7:0]  cur_status = '0;
  logic [7:0]  running_status = '0;
  logic [7:0]  first_data = '0;
  logic [7:0]  meta_type = '0;
  logic [31:0] payload_left = '0;
  logic [63:0] pack_buf = '0;
  logic [2:0]  pack_pos = '0;
  logic        track_done = 1'b0;

  unit_t       expected_units[$];
  bit          start_pending = 1'b0;
  bit          calm = 1'b0;
  int unsigned items_sent = 0;
  int unsigned fail_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;

  function automatic unit_t make_unit(logic [31:0] lo, logic [31:0] hi, logic [1:0] kind,
                                      logic last);
    unit_t u;
    u.lo = lo;
    u.hi = hi;
    u.kind = kind;
    u.last = last;
    return u;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic st);
    unit_t       u;
    bit          produced;
    logic [31:0] len;
    logic [31:0] reported;
    int unsigned nxt;
    produced = 1'b0;
    u = '0;
    if (st) begin
      phase = WAIT_DELTA;
      vlq_acc = '0;
      held_delta = '0;
      cur_status = '0;
      running_status = '0;
      first_data = '0;
      meta_type = '0;
      payload_left = '0;
      pack_buf = '0;
      pack_pos = '0;
      track_done = 1'b0;
    end
    if (!track_done) begin
      // A data byte where a status is due reuses the running status.
      if (phase == WAIT_STATUS && !b[7]) begin
        cur_status = running_status;
        phase = WAIT_DATA1;
      end
      case (phase)
        WAIT_DELTA: begin
          vlq_acc = (vlq_acc << 7) + {25'd0, b[6:0]};
          if (!b[7]) begin
            held_delta = vlq_acc;
            vlq_acc = '0;
            phase = WAIT_STATUS;
          end
        end
        WAIT_STATUS: begin
          cur_status = b;
          if (b[7:4] != mtep_pkg::NIBBLE_SYSTEM) begin
            phase = WAIT_DATA1;
          end else if (b == mtep_pkg::STATUS_META) begin
            running_status = '0;
            phase = WAIT_META_TYPE;
          end else if (b == mtep_pkg::STATUS_SYSEX || b == mtep_pkg::STATUS_ESCAPE) begin
            running_status = '0;
            phase = WAIT_LENGTH;
            u = make_unit(held_delta, {24'd0, b}, mtep_pkg::KIND_HEADER, 1'b0);
            produced = 1'b1;
          end else begin
            phase = WAIT_DELTA;
            u = make_unit(held_delta, 32'd0, mtep_pkg::KIND_HEADER, 1'b0);
            produced = 1'b1;
          end
        end
        WAIT_DATA1: begin
          first_data = b;
          if (cur_status[7:4] == mtep_pkg::NIBBLE_PROG ||
              cur_status[7:4] == mtep_pkg::NIBBLE_PRESS) begin
            running_status = cur_status;
            phase = WAIT_DELTA;
            u = make_unit(held_delta, {16'd0, b, cur_status}, mtep_pkg::KIND_HEADER, 1'b0);
            produced = 1'b1;
          end else begin
            phase = WAIT_DATA2;
          end
        end
        WAIT_DATA2: begin
          running_status = cur_status;
          phase = WAIT_DELTA;
          u = make_unit(held_delta, {8'd0, b, first_data, cur_status},
                        mtep_pkg::KIND_HEADER, 1'b0);
          produced = 1'b1;
        end
        WAIT_META_TYPE: begin
          meta_type = b;
          phase = WAIT_LENGTH;
          if (b != mtep_pkg::META_END) begin
            u = make_unit(held_delta, {16'd0, b, mtep_pkg::STATUS_META},
                          mtep_pkg::KIND_HEADER, 1'b0);
            produced = 1'b1;
          end
        end
        WAIT_LENGTH: begin
          vlq_acc = (vlq_acc << 7) + {25'd0, b[6:0]};
          if (!b[7]) begin
            len = vlq_acc;
            vlq_acc = '0;
            produced = 1'b1;
            if (cur_status == mtep_pkg::STATUS_META && meta_type == mtep_pkg::META_END) begin
              track_done = 1'b1;
              phase = WAIT_DELTA;
              u = make_unit(32'd0, 32'd0, mtep_pkg::KIND_END, 1'b1);
            end else begin
              reported = len;
              pack_buf = '0;
              pack_pos = '0;
              payload_left = len;
              if (cur_status == mtep_pkg::STATUS_SYSEX && len != 0) begin
                reported = (len == 32'hFFFF_FFFF) ? len : len + 1;
                pack_buf = {56'd0, mtep_pkg::STATUS_SYSEX};
                pack_pos = 3'd1;
              end
              phase = (len != 0) ? WAIT_PAYLOAD : WAIT_DELTA;
              u = make_unit(reported, reported / mtep_pkg::UNIT_BYTES +
                            ((reported % mtep_pkg::UNIT_BYTES) != 0),
                            mtep_pkg::KIND_LENGTH, 1'b0);
            end
          end
        end
        WAIT_PAYLOAD: begin
          pack_buf = pack_buf | ({56'd0, b} << (8 * pack_pos));
          nxt = pack_pos + 1;
          payload_left = payload_left - 1;
          if (nxt >= mtep_pkg::UNIT_BYTES || payload_left == 0) begin
            u = make_unit(pack_buf[31:0], pack_buf[63:32], mtep_pkg::KIND_PAYLOAD, 1'b0);
            produced = 1'b1;
            pack_buf = '0;
            pack_pos = '0;
            if (payload_left == 0) phase = WAIT_DELTA;
          end else begin
            pack_pos = nxt[2:0];
          end
        end
        default: phase = WAIT_DELTA;
      endcase
    end
    if (produced) expected_units.push_back(u);
  endtask

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    logic        st;
    st = start_pending;
    start_pending = 1'b0;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= st;
    do @(posedge clk); while (!in_tready);
    if (st || !track_done) items_sent++;
    parse_byte(b, st);
  endtask

  task automatic send_seq(input byte_seq_t seq);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic send_vlq(input logic [31:0] value);
    int groups;
    groups = 1;
    while (groups < 5 && (value >> (7 * groups)) != 0) groups++;
    for (int i = groups - 1; i >= 0; i--)
      send_byte({i > 0, 7'(value >> (7 * i))});
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_units.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_units
    unit_t want;
    unit_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = make_unit(out_tdata[31:0], out_tdata[63:32], out_tuser, out_tlast);
      if (expected_units.size() == 0) begin
        fail_count++;
        if (mismatch_count < 10)
          $display("unexpected beat: lo=%h hi=%h kind=%0d last=%0b",
                   got.lo, got.hi, got.kind, got.last);
        mismatch_count++;
      end else begin
        want = expected_units.pop_front();
        if (got.lo !== want.lo || got.hi !== want.hi || got.kind !== want.kind ||
            got.last !== want.last) begin
          fail_count++;
          if (mismatch_count < 10)
            $display("mismatch: expected lo=%h hi=%h kind=%0d last=%0b,",
                     want.lo, want.hi, want.kind, want.last,
                     " got lo=%h hi=%h kind=%0d last=%0b",
                     got.lo, got.hi, got.kind, got.last);
          mismatch_count++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_channel_events();
    start_pending = 1'b1;
    send_seq('{8'h00, 8'h05, 8'h06});
    send_seq('{8'h00, 8'h90, 8'hBC, 8'hC0});
    send_seq('{8'h81, 8'h00, 8'h3D, 8'h7F});
    send_seq('{8'h00, 8'hC5, 8'hFF});
    send_seq('{8'h00, 8'h20});
    wait_drained();
  endtask

  task automatic test_meta_and_sysex();
    send_seq('{8'h00, 8'hFF, 8'h01, 8'h02, 8'h41, 8'h42});
    send_seq('{8'h00, 8'h10, 8'h20});
    send_seq('{8'h00, 8'hF0, 8'h00});
    send_seq('{8'h00, 8'hF7, 8'h03, 8'h01, 8'h02, 8'hF7});
    wait_drained();
  endtask

  task automatic test_unknown_status();
    send_seq('{8'h00, 8'hF4, 8'h00, 8'hFE});
    wait_drained();
  endtask

  task automatic test_end_of_track();
    send_seq('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h2F, 8'h00, 8'h55, 8'h90});
    wait_drained();
  endtask

  task automatic test_length_extremes();
    start_pending = 1'b1;
    send_seq('{8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hF0, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F});
    send_seq('{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07});
    wait_drained();
  endtask

  task automatic send_random_event();
    int unsigned pick;
    int unsigned len;
    int unsigned count;
    logic [7:0]  code;
    pick = $urandom_range(0, 99);
    if (pick < 70) send_vlq($urandom_range(0, 127));
    else if (pick < 90) send_vlq($urandom_range(128, 16383));
    else if (pick < 98) send_vlq($urandom_range(0, 32'h0FFF_FFFF));
    else begin
      // Over-long delta: the accumulator wraps.
      count = $urandom_range(4, 5);
      repeat (count) send_byte({1'b1, 7'($urandom)});
      send_byte({1'b0, 7'($urandom)});
    end
    pick = $urandom_range(0, 99);
    len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 16) : $urandom_range(17, 40);
    if (pick < 35) begin
      code = 8'($urandom_range(8'h80, 8'hEF));
      send_byte(code);
      send_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127)));
      if (code[7:4] != mtep_pkg::NIBBLE_PROG && code[7:4] != mtep_pkg::NIBBLE_PRESS)
        send_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127)));
    end else if (pick < 60) begin
      code = running_status;
      send_byte(8'($urandom_range(0, 127)));
      if (code[7:4] != mtep_pkg::NIBBLE_PROG && code[7:4] != mtep_pkg::NIBBLE_PRESS)
        send_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127)));
    end else if (pick < 75) begin
      code = 8'($urandom_range(0, 127));
      if (code == mtep_pkg::META_END) code = 8'h01;
      send_byte(mtep_pkg::STATUS_META);
      send_byte(code);
      send_vlq(len);
      repeat (len) send_byte(8'($urandom));
    end else if (pick < 87) begin
      send_byte($urandom_range(0, 1) ? mtep_pkg::STATUS_SYSEX : mtep_pkg::STATUS_ESCAPE);
      send_vlq(len);
      repeat (len) send_byte(8'($urandom));
    end else if (pick < 92) begin
      do code = 8'($urandom_range(8'hF1, 8'hFE)); while (code == mtep_pkg::STATUS_ESCAPE);
      send_byte(code);
    end else if (pick < 96) begin
      send_byte(mtep_pkg::STATUS_META);
      send_byte(mtep_pkg::META_END);
      send_vlq(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      count = $urandom_range(0, 3);
      repeat (count) send_byte(8'($urandom));
      start_pending = 1'b1;
    end else begin
      count = $urandom_range(1, 6);
      repeat (count) send_byte(8'($urandom));
      if ($urandom_range(0, 9) != 0) start_pending = 1'b1;
    end
    if ($urandom_range(0, 49) == 0) start_pending = 1'b1;
  endtask

  task automatic test_random_stream();
    int unsigned target;
    int unsigned next_mode;
    int unsigned next_drain;
    target = items_sent + RANDOM_ITEMS;
    next_mode = items_sent + 100;
    next_drain = items_sent + 200;
    start_pending = 1'b1;
    while (items_sent < target) begin
      send_random_event();
      if (items_sent >= next_mode) begin
        calm = ($urandom_range(0, 3) == 0);
        next_mode = items_sent + 100;
      end
      if (items_sent >= next_drain) begin
        wait_drained();
        next_drain = items_sent + 200;
      end
    end
    calm = 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_channel_events();
    test_meta_and_sysex();
    test_unknown_status();
    test_end_of_track();
    test_length_extremes();
    test_random_stream();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_units.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- midi_track_event_parser.f -----
+incdir+design
design/mtep_pkg.sv
design/mtep_front.sv
design/mtep_queue.sv
design/mtep_back.sv
design/midi_track_event_parser.sv
tb/midi_track_event_parser_tb.sv
